@@ sv/assert_macros.svh @@
// Assertion helpers for the RTL; clk and rst_n are taken from the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ sv/wma_pkg.sv @@
`timescale 1ns / 1ps

package wma_pkg;

    // Field widths
    localparam int SAMPLE_W = 48;
    localparam int SUM_W    = 58;
    localparam int AVG_W    = 56;
    localparam int CNT_W    = 11;
    localparam int FRAC_W   = 8;

    // Divider: one quotient bit per step over the scaled sum
    localparam int DIV_W     = SUM_W + FRAC_W;
    localparam int DIV_STEPS = DIV_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Storage defaults
    localparam int MAX_WINDOW_DEF = 1024;
    localparam int WIN_RESET      = 1024;

    // Input commands
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUB,
        S_ADD,
        S_DIV,
        S_DONE
    } wma_state_t;

endpackage

@@ sv/windowed_moving_average.sv @@
`timescale 1ns / 1ps
// Insert: old entry read at the accept edge, then subtract (when full), add, bit-serial
//   restoring divide at one quotient bit per cycle, output load. Clear: output load only.
// A new transaction is taken only in idle, once the last result is in the output register.
// A finished result waits in the output register while the next transaction is taken.
// Reset (rst_n, async low): window_len = 1024 (capped at MAX_WINDOW), position, count and
//   sum cleared, output empty; sample memory is not cleared.

`include "assert_macros.svh"

module windowed_moving_average
    import wma_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CNT_W-1:0]    cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                cmd,
    input  logic [SAMPLE_W-1:0] sample,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [AVG_W-1:0]    average,
    output logic [CNT_W-1:0]    valid_count
);

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam logic [CNT_W-1:0] WLEN_RST =
        (WIN_RESET <= MAX_WINDOW) ? CNT_W'(WIN_RESET) : CNT_W'(MAX_WINDOW);

    wma_state_t state_reg, state_next;

    logic [CNT_W-1:0]    wlen_reg, wlen_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SAMPLE_W-1:0] smp_reg, smp_next;
    logic                full_reg, full_next;
    logic [DIV_W-1:0]    dvd_reg, dvd_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [AVG_W-1:0]    quot_reg, quot_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                oval_reg, oval_next;
    logic [AVG_W-1:0]    avg_reg, avg_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    logic [SAMPLE_W-1:0] mem [MAX_WINDOW];
    logic [SAMPLE_W-1:0] old_reg;

    logic                accept;
    logic                mem_we;
    logic [CNT_W-1:0]    win;
    logic [AW-1:0]       pos_eff;
    logic [CNT_W-1:0]    fill_eff;
    logic                full_now;
    logic [SUM_W-1:0]    sum_add;
    logic [CNT_W:0]      rem_shift;
    logic                div_ge;
    logic                out_free;

    assign in_ready    = (state_reg == S_IDLE);
    assign accept      = in_valid && in_ready;
    assign out_valid   = oval_reg;
    assign average     = avg_reg;
    assign valid_count = cnt_reg;
    assign out_free    = !oval_reg || out_ready;

    // Effective window: zero acts as one, capped at the storage depth
    always_comb
    begin
        win = wlen_reg;
        if (wlen_reg == '0)
            win = CNT_W'(1);
        if (32'(wlen_reg) > MAX_WINDOW)
            win = CNT_W'(MAX_WINDOW);
    end

    // Position and count as seen by the incoming transaction
    always_comb
    begin
        pos_eff  = (32'(pos_reg) >= 32'(win)) ? '0 : pos_reg;
        fill_eff = (fill_reg > win) ? win : fill_reg;
        full_now = (fill_eff == win);
    end

    assign mem_we  = accept && (cmd == CMD_INSERT);
    assign sum_add = sum_reg + SUM_W'(smp_reg);

    // Divider step: shift in one dividend bit, subtract when it fits
    assign rem_shift = {rem_reg, dvd_reg[DIV_W-1]};
    assign div_ge    = (rem_shift >= {1'b0, fill_reg});

    // Sample memory: old entry read while the new one is written
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            old_reg      <= mem[pos_eff];
            mem[pos_eff] <= sample;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = (cmd == CMD_CLEAR) ? S_DONE : S_SUB;
            end
            S_SUB:  state_next = S_ADD;
            S_ADD:  state_next = S_DIV;
            S_DIV:
            begin
                if (step_reg == '0)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and output register updates
    always_comb
    begin
        wlen_next = wlen_reg;
        pos_next  = pos_reg;
        fill_next = fill_reg;
        sum_next  = sum_reg;
        smp_next  = smp_reg;
        full_next = full_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        step_next = step_reg;
        oval_next = oval_reg;
        avg_next  = avg_reg;
        cnt_next  = cnt_reg;

        if (oval_reg && out_ready)
            oval_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == CMD_CLEAR)
                    begin
                        pos_next  = '0;
                        fill_next = '0;
                        sum_next  = '0;
                        quot_next = '0;
                    end
                    else
                    begin
                        smp_next  = sample;
                        full_next = full_now;
                        pos_next  = (32'(pos_eff) + 1 >= 32'(win)) ? '0 : pos_eff + AW'(1);
                        fill_next = full_now ? fill_eff : fill_eff + CNT_W'(1);
                    end
                end
            end
            S_SUB:
            begin
                if (full_reg)
                    sum_next = sum_reg - SUM_W'(old_reg);
            end
            S_ADD:
            begin
                sum_next  = sum_add;
                dvd_next  = {sum_add, FRAC_W'(0)};
                rem_next  = '0;
                quot_next = '0;
                step_next = STEP_W'(DIV_STEPS - 1);
            end
            S_DIV:
            begin
                rem_next  = div_ge ? CNT_W'(rem_shift - {1'b0, fill_reg}) : rem_shift[CNT_W-1:0];
                quot_next = {quot_reg[AVG_W-2:0], div_ge};
                dvd_next  = {dvd_reg[DIV_W-2:0], 1'b0};
                step_next = step_reg - STEP_W'(1);
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    oval_next = 1'b1;
                    avg_next  = quot_reg;
                    cnt_next  = fill_reg;
                end
            end
            default: ;
        endcase

        // Window length write empties the window
        if (cfg_we)
        begin
            wlen_next = cfg_wdata;
            pos_next  = '0;
            fill_next = '0;
            sum_next  = '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wlen_reg  <= WLEN_RST;
            pos_reg   <= '0;
            fill_reg  <= '0;
            sum_reg   <= '0;
            step_reg  <= '0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wlen_reg  <= wlen_next;
            pos_reg   <= pos_next;
            fill_reg  <= fill_next;
            sum_reg   <= sum_next;
            step_reg  <= step_next;
            oval_reg  <= oval_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        smp_reg  <= smp_next;
        full_reg <= full_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        avg_reg  <= avg_next;
        cnt_reg  <= cnt_next;
    end

    // Checks
    `ASSERT_CLK(a_fill_in_window, fill_reg <= win, "fill count above window")
    `ASSERT_CLK(a_rem_below_div, (state_reg == S_DIV) |-> (rem_reg < fill_reg),
                "divider remainder not below divisor")
    `ASSERT_CLK(a_out_from_done, $rose(oval_reg) |-> $past(state_reg == S_DONE),
                "result raised outside output load")
    `ASSERT_CLK(a_clear_empties,
                (accept && (cmd == CMD_CLEAR)) |=> (fill_reg == '0 && sum_reg == '0),
                "clear left window state")
    `ASSERT_NEVER(a_pos_range,
                  (state_reg == S_IDLE) && (32'(pos_reg) >= 32'(win)) && !$past(cfg_we),
                  "write position outside window")

endmodule

@@ tb/sv/mean_checker.sv @@
`timescale 1ns / 1ps

// Watches the config port and both channels of the moving-average block,
// keeps its own copy of the window state and checks every returned mean.
module mean_checker
    import wma_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CNT_W-1:0]    cfg_wdata,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                cmd,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [AVG_W-1:0]    average,
    input  logic [CNT_W-1:0]    valid_count,
    output int                  mismatches,
    output int                  outstanding
);

    localparam int POS_W = $clog2(MAX_WINDOW);

    typedef struct packed {
        logic [AVG_W-1:0] average;
        logic [CNT_W-1:0] count;
    } mean_result_t;

    // Shadow copy of the window
    logic [SAMPLE_W-1:0] window_mem [MAX_WINDOW];
    logic [POS_W-1:0]    head;
    logic [CNT_W-1:0]    filled;
    logic [SUM_W-1:0]    total;
    logic [CNT_W-1:0]    win_setting;

    mean_result_t expected_means [$];

    initial mismatches = 0;
    initial outstanding = 0;

    // Advance the shadow window by one transaction and work out its result
    task automatic update_mean(input logic op, input logic [SAMPLE_W-1:0] value,
                               output mean_result_t res);
        int                     span;
        logic [SUM_W+FRAC_W-1:0] scaled;
        span = (win_setting == 0) ? 1 : int'(win_setting);
        if (span > MAX_WINDOW)
            span = MAX_WINDOW;
        if (op == CMD_CLEAR)
        begin
            head   = '0;
            filled = '0;
            total  = '0;
            res    = '0;
        end
        else
        begin
            if (32'(head) >= span)
                head = '0;
            if (32'(filled) > span)
                filled = CNT_W'(span);
            // full window: the oldest sample drops out of the sum
            if (32'(filled) == span)
                total = total - SUM_W'(window_mem[head]);
            window_mem[head] = value;
            total = total + SUM_W'(value);
            head = (32'(head) + 1 >= span) ? '0 : head + POS_W'(1);
            if (32'(filled) < span)
                filled = filled + CNT_W'(1);
            res.count = filled;
            if (filled == '0)
                res.average = '0;
            else
            begin
                // floor(sum * 256 / count)
                scaled = {total, {FRAC_W{1'b0}}};
                res.average = AVG_W'(scaled / filled);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        mean_result_t predicted;
        if (!rst_n)
        begin
            head        = '0;
            filled      = '0;
            total       = '0;
            win_setting = CNT_W'(WIN_RESET);
            expected_means.delete();
            outstanding <= 0;
        end
        else
        begin
            // a register write empties the window
            if (cfg_we)
            begin
                win_setting = cfg_wdata;
                head        = '0;
                filled      = '0;
                total       = '0;
            end

            if (in_valid && in_ready)
            begin
                update_mean(cmd, sample, predicted);
                expected_means.push_back(predicted);
            end

            if (out_valid && out_ready)
            begin
                if (expected_means.size() == 0)
                begin
                    $error("unexpected result transaction: average %0h, valid_count %0d",
                           average, valid_count);
                    mismatches++;
                end
                else
                begin
                    predicted = expected_means.pop_front();
                    if (average !== predicted.average)
                    begin
                        $error("average: expected %0h, got %0h", predicted.average, average);
                        mismatches++;
                    end
                    if (valid_count !== predicted.count)
                    begin
                        $error("valid_count: expected %0d, got %0d",
                               predicted.count, valid_count);
                        mismatches++;
                    end
                end
            end

            outstanding <= expected_means.size();
        end
    end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import wma_pkg::*;

    localparam int LONG_HOLD   = 600;
    localparam int DRAIN_LIMIT = 5000;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {SAMPLE_W{1'b1}};

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [CNT_W-1:0]    cfg_wdata = '0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    logic                cmd       = CMD_INSERT;
    logic [SAMPLE_W-1:0] sample    = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [AVG_W-1:0]    average;
    logic [CNT_W-1:0]    valid_count;

    int mismatches;
    int outstanding;
    int hold_ask = 0;

    // sender burst state
    bit bursty;
    int burst_left;

    windowed_moving_average dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .sample      (sample),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .average     (average),
        .valid_count (valid_count)
    );

    mean_checker mean_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .sample      (sample),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .average     (average),
        .valid_count (valid_count),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Result side: segments of always-ready, coin-flip, ready when the tick count is a multiple of four
    // and full stall; a requested long hold lets the block back up
    initial
    begin : result_sink
        int mode;
        int span;
        int tick;
        int hold_seen;
        hold_seen = 0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = (mode == 3) ? $urandom_range(5, 60) : $urandom_range(20, 300);
            for (tick = 0; tick < span; tick++)
            begin
                @(posedge clk);
                if (hold_ask != hold_seen)
                begin
                    hold_seen = hold_ask;
                    out_ready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge clk);
                end
                else
                begin
                    case (mode)
                        0: out_ready <= 1'b1;
                        1: out_ready <= $urandom_range(0, 1);
                        2: out_ready <= (tick % 4 == 0);
                        default: out_ready <= 1'b0;
                    endcase
                end
            end
        end
    end

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        logic [SAMPLE_W-1:0] s;
        case ($urandom_range(0, 7))
            0: s = '0;
            1: s = SAMPLE_MAX;
            2: s = SAMPLE_W'($urandom_range(0, 255));
            3, 4: s = SAMPLE_W'({$urandom, $urandom});
            5: s = SAMPLE_MAX - SAMPLE_W'($urandom_range(0, 1000));
            6: s = SAMPLE_W'(1) << $urandom_range(0, SAMPLE_W - 1);
            default: s = SAMPLE_W'($urandom);
        endcase
        return s;
    endfunction

    // Offer one transaction and hold it until taken
    task automatic send_item(input logic op, input logic [SAMPLE_W-1:0] value);
        cmd      <= op;
        sample   <= value;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
    endtask

    // Gap between bursts: mostly short, sometimes longer than one divide
    task automatic pace();
        if (bursty)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                in_valid <= 1'b0;
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(20, 120)) @(posedge clk);
                else
                    repeat ($urandom_range(1, 8)) @(posedge clk);
                burst_left = $urandom_range(0, 12);
            end
        end
    endtask

    // Stop sending until every predicted result has come back
    task automatic wait_for_results();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
            waited++;
            if (waited > DRAIN_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    endtask

    // Only called with the block idle
    task automatic write_window(input logic [CNT_W-1:0] len);
        repeat (4) @(posedge clk);
        cfg_wdata <= len;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input int len, input int count, input bit clears,
                             input bit hold, input bit mid_drain);
        int k;
        write_window(CNT_W'(len));
        if (hold)
            hold_ask <= hold_ask + 1;
        bursty     = ($urandom_range(0, 3) != 0);
        burst_left = $urandom_range(0, 12);
        for (k = 0; k < count; k++)
        begin
            if (clears && $urandom_range(0, 24) == 0)
                send_item(CMD_CLEAR, pick_sample());
            else
                send_item(CMD_INSERT, pick_sample());
            if (mid_drain && k == count / 2)
                wait_for_results();
            else
                pace();
        end
        wait_for_results();
    endtask

    initial
    begin : stimulus
        bursty     = 1'b0;
        burst_left = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Window after reset: sample extremes, clear with junk sample, clear when empty
        send_item(CMD_INSERT, '0);
        send_item(CMD_INSERT, SAMPLE_MAX);
        send_item(CMD_INSERT, 48'd1);
        send_item(CMD_INSERT, 48'd3);
        send_item(CMD_CLEAR, SAMPLE_MAX);
        send_item(CMD_CLEAR, '0);
        wait_for_results();

        // Zero length behaves as a window of one
        write_window('0);
        send_item(CMD_INSERT, SAMPLE_MAX);
        send_item(CMD_INSERT, 48'd5);
        send_item(CMD_INSERT, '0);
        wait_for_results();

        write_window(CNT_W'(1));
        send_item(CMD_INSERT, 48'd7);
        wait_for_results();

        // Full window of maximum samples, then overwrite and clear
        write_window(CNT_W'(2));
        send_item(CMD_INSERT, SAMPLE_MAX);
        send_item(CMD_INSERT, SAMPLE_MAX);
        send_item(CMD_INSERT, SAMPLE_MAX);
        send_item(CMD_INSERT, 48'd1);
        send_item(CMD_CLEAR, 48'd9);
        send_item(CMD_INSERT, 48'd2);
        wait_for_results();

        // Random phases; oversize length is capped at the store depth
        run_phase(5, 50, 1'b1, 1'b1, 1'b0);
        run_phase(2047, 300, 1'b0, 1'b0, 1'b0);
        run_phase(1, 40, 1'b1, 1'b0, 1'b0);
        run_phase(0, 40, 1'b1, 1'b0, 1'b0);
        run_phase(2, 50, 1'b1, 1'b1, 1'b1);
        run_phase(16, 60, 1'b1, 1'b0, 1'b0);
        run_phase(100, 100, 1'b1, 1'b0, 1'b0);
        run_phase($urandom_range(3, 40), 50, 1'b1, 1'b0, 1'b1);
        run_phase(1024, 30, 1'b1, 1'b0, 1'b0);

        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
